// File: hdl/fft8_pkg.sv
// ----------------------------------------------------------------------------
// fft8_pkg
// Shared constants, types and the twiddle constant for the 8-point FFT core.
// ----------------------------------------------------------------------------
package fft8_pkg;

  // Default sample width and twiddle fraction width.
  localparam int SAMPLE_WIDTH_DEF      = 16;
  localparam int TWIDDLE_FRAC_BITS_DEF = 15;

  // Transform size and result format.
  localparam int NPOINT    = 8;
  localparam int IDX_WIDTH = 3;
  localparam int BIN_WIDTH = 20;

  // Number of complete frames that may wait between the front and back ends.
  localparam int FRAME_FIFO_DEPTH = 2;

  // Last bin and last sample of a frame.
  localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(NPOINT - 1);

  // Butterfly engine sequencer states.
  typedef enum logic [3:0] {
    ENG_IDLE = 4'b0001,
    ENG_ST2  = 4'b0010,
    ENG_TWID = 4'b0100,
    ENG_ST3  = 4'b1000
  } eng_state_t;

  // Round(2^f / sqrt(2)) by an integer square root; evaluated at elaboration.
  function automatic longint unsigned twiddle_c(input int f);
    longint unsigned t;
    longint unsigned c;
    longint unsigned cand;
    t = 64'd1 << (2 * f - 1);
    c = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      cand = c | (64'd1 << b);
      if (cand * cand <= t) begin
        c = cand;
      end
    end
    if (4 * c * c + 4 * c + 1 < 4 * t) begin
      c = c + 1;
    end
    return c;
  endfunction

endpackage

// File: hdl/fft8_front.sv
// ----------------------------------------------------------------------------
// fft8_front
// Collects incoming samples and hands each complete frame to the frame queue.
// ----------------------------------------------------------------------------
module fft8_front #(
  parameter int SAMPLE_WIDTH = fft8_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_im,
  input  logic                                   fifo_full,
  output logic                                   frame_push,
  output logic [fft8_pkg::NPOINT*2*SAMPLE_WIDTH-1:0] frame
);

  localparam int SW = 2 * SAMPLE_WIDTH;

  logic [fft8_pkg::IDX_WIDTH-1:0] sample_count;
  logic [fft8_pkg::IDX_WIDTH-1:0] sample_count_next;
  logic [SW-1:0]                  sample_store [fft8_pkg::NPOINT-1];
  logic                           beat;
  logic                           frame_end;

  // The eighth sample can only be taken when the queue has room for the frame.
  assign frame_end  = (sample_count == fft8_pkg::LAST_IDX);
  assign full       = frame_end && fifo_full;
  assign beat       = push && !full;
  assign frame_push = beat && frame_end;

  // The frame is the buffered samples plus the one arriving now.
  always_comb begin
    for (int k = 0; k < fft8_pkg::NPOINT - 1; k++) begin
      frame[k*SW +: SW] = sample_store[k];
    end
    frame[(fft8_pkg::NPOINT-1)*SW +: SW] = {sample_im, sample_re};
  end

  // Sample counter wraps at the end of each frame.
  always_comb begin
    sample_count_next = sample_count;
    if (beat) begin
      sample_count_next = frame_end ? '0 : sample_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else begin
      sample_count <= sample_count_next;
    end
  end

  // Sample buffer; the final sample goes straight into the frame.
  always_ff @(posedge clk) begin
    if (beat && !frame_end) begin
      sample_store[sample_count] <= {sample_im, sample_re};
    end
  end

endmodule

// File: hdl/fft8_frame_fifo.sv
// ----------------------------------------------------------------------------
// fft8_frame_fifo
// Short queue of complete frames between the front end and the butterfly
// engine.
// ----------------------------------------------------------------------------
module fft8_frame_fifo #(
  parameter int WIDTH = 2 * fft8_pkg::NPOINT * fft8_pkg::SAMPLE_WIDTH_DEF,
  parameter int DEPTH = fft8_pkg::FRAME_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Frame storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  // Occupancy never exceeds the number of slots.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("frame queue occupancy out of range");

  // The front end never offers a frame while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full))
    else $error("frame offered to a full queue");

  // A write without a read grows the occupancy by one.
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("frame queue occupancy did not grow");
`endif

endmodule

// File: hdl/fft8_engine.sv
// ----------------------------------------------------------------------------
// fft8_engine
// Butterfly sequencer: runs the three radix-2 stages on one frame and holds
// the eight bins in a result bank that drains one beat per pop.
// ----------------------------------------------------------------------------
module fft8_engine #(
  parameter int SAMPLE_WIDTH      = fft8_pkg::SAMPLE_WIDTH_DEF,
  parameter int TWIDDLE_FRAC_BITS = fft8_pkg::TWIDDLE_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        frame_valid,
  input  logic [fft8_pkg::NPOINT*2*SAMPLE_WIDTH-1:0]  frame,
  output logic                                        frame_pop,
  output logic                                        empty,
  input  logic                                        pop,
  output logic signed [fft8_pkg::BIN_WIDTH-1:0]       bin_re,
  output logic signed [fft8_pkg::BIN_WIDTH-1:0]       bin_im,
  output logic [fft8_pkg::IDX_WIDTH-1:0]              bin_index,
  output logic                                        last_bin
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int N  = fft8_pkg::NPOINT;
  localparam int F  = TWIDDLE_FRAC_BITS;
  // Three stages of growth plus headroom for the twiddle rounding.
  localparam int IW = SAMPLE_WIDTH + 4;
  localparam int CW = F + 2;
  localparam int PW = IW + CW;
  localparam longint unsigned CVAL = fft8_pkg::twiddle_c(F);
  localparam logic signed [CW-1:0] C_S  = CW'(CVAL);
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);

  typedef logic signed [IW-1:0] val_t;

  fft8_pkg::eng_state_t state;
  fft8_pkg::eng_state_t state_next;

  val_t wre [N];
  val_t wim [N];
  val_t wre_next [N];
  val_t wim_next [N];
  val_t sre [N];
  val_t sim [N];
  val_t m5r;
  val_t m5i;
  val_t m7r;
  val_t m7i;
  val_t bre_next [N];
  val_t bim_next [N];
  val_t bank_re [N];
  val_t bank_im [N];

  logic                           bank_busy;
  logic                           bank_busy_next;
  logic [fft8_pkg::IDX_WIDTH-1:0] idx;
  logic [fft8_pkg::IDX_WIDTH-1:0] idx_next;
  logic                           bank_free;
  logic                           bank_load;
  logic                           out_beat;

  // Product with the twiddle constant, rounded to nearest (ties upward).
  function automatic val_t mul_round(input val_t x);
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;
    prod = PW'(x) * PW'(C_S);
    rnd  = prod + HALF;
    return IW'(rnd >>> F);
  endfunction

  // Unpack the queued frame into widened samples.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      sre[k] = IW'($signed(frame[k*2*SW +: SW]));
      sim[k] = IW'($signed(frame[k*2*SW + SW +: SW]));
    end
  end

  // Result bank handshake.
  assign out_beat  = pop && bank_busy;
  assign bank_free = !bank_busy || (out_beat && idx == fft8_pkg::LAST_IDX);
  assign bank_load = (state == fft8_pkg::ENG_ST3) && bank_free;
  assign frame_pop = (state == fft8_pkg::ENG_IDLE) && frame_valid;

  // Sequencer and the first two butterfly stages, computed in place.
  always_comb begin
    state_next = state;
    wre_next   = wre;
    wim_next   = wim;
    case (state)
      fft8_pkg::ENG_IDLE: begin
        if (frame_valid) begin
          wre_next[0] = sre[0] + sre[4]; wim_next[0] = sim[0] + sim[4];
          wre_next[1] = sre[0] - sre[4]; wim_next[1] = sim[0] - sim[4];
          wre_next[2] = sre[2] + sre[6]; wim_next[2] = sim[2] + sim[6];
          wre_next[3] = sre[2] - sre[6]; wim_next[3] = sim[2] - sim[6];
          wre_next[4] = sre[1] + sre[5]; wim_next[4] = sim[1] + sim[5];
          wre_next[5] = sre[1] - sre[5]; wim_next[5] = sim[1] - sim[5];
          wre_next[6] = sre[3] + sre[7]; wim_next[6] = sim[3] + sim[7];
          wre_next[7] = sre[3] - sre[7]; wim_next[7] = sim[3] - sim[7];
          state_next  = fft8_pkg::ENG_ST2;
        end
      end
      fft8_pkg::ENG_ST2: begin
        wre_next[0] = wre[0] + wre[2]; wim_next[0] = wim[0] + wim[2];
        wre_next[2] = wre[0] - wre[2]; wim_next[2] = wim[0] - wim[2];
        wre_next[1] = wre[1] + wim[3]; wim_next[1] = wim[1] - wre[3];
        wre_next[3] = wre[1] - wim[3]; wim_next[3] = wim[1] + wre[3];
        wre_next[4] = wre[4] + wre[6]; wim_next[4] = wim[4] + wim[6];
        wre_next[6] = wre[4] - wre[6]; wim_next[6] = wim[4] - wim[6];
        wre_next[5] = wre[5] + wim[7]; wim_next[5] = wim[5] - wre[7];
        wre_next[7] = wre[5] - wim[7]; wim_next[7] = wim[5] + wre[7];
        state_next  = fft8_pkg::ENG_TWID;
      end
      fft8_pkg::ENG_TWID: begin
        state_next = fft8_pkg::ENG_ST3;
      end
      fft8_pkg::ENG_ST3: begin
        if (bank_free) begin
          state_next = fft8_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_next = fft8_pkg::ENG_IDLE;
      end
    endcase
  end

  // Final stage into natural bin order.
  always_comb begin
    bre_next[0] = wre[0] + wre[4]; bim_next[0] = wim[0] + wim[4];
    bre_next[4] = wre[0] - wre[4]; bim_next[4] = wim[0] - wim[4];
    bre_next[1] = wre[1] + m5r;    bim_next[1] = wim[1] + m5i;
    bre_next[5] = wre[1] - m5r;    bim_next[5] = wim[1] - m5i;
    bre_next[2] = wre[2] + wim[6]; bim_next[2] = wim[2] - wre[6];
    bre_next[6] = wre[2] - wim[6]; bim_next[6] = wim[2] + wre[6];
    bre_next[3] = wre[3] + m7r;    bim_next[3] = wim[3] + m7i;
    bre_next[7] = wre[3] - m7r;    bim_next[7] = wim[3] - m7i;
  end

  // Bank occupancy and read index.
  always_comb begin
    bank_busy_next = bank_busy;
    idx_next       = idx;
    if (bank_load) begin
      bank_busy_next = 1'b1;
      idx_next       = '0;
    end else if (out_beat) begin
      idx_next = idx + 1'b1;
      if (idx == fft8_pkg::LAST_IDX) begin
        bank_busy_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fft8_pkg::ENG_IDLE;
      bank_busy <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      bank_busy <= bank_busy_next;
      idx       <= idx_next;
    end
  end

  // Working values, twiddle products and the result bank.
  always_ff @(posedge clk) begin
    wre <= wre_next;
    wim <= wim_next;
    if (state == fft8_pkg::ENG_TWID) begin
      m5r <= mul_round(wre[5] + wim[5]);
      m5i <= mul_round(wim[5] - wre[5]);
      m7r <= mul_round(wim[7] - wre[7]);
      m7i <= mul_round(-(wre[7] + wim[7]));
    end
    if (bank_load) begin
      bank_re <= bre_next;
      bank_im <= bim_next;
    end
  end

  // Result beat.
  assign empty     = !bank_busy;
  assign bin_re    = fft8_pkg::BIN_WIDTH'(bank_re[idx]);
  assign bin_im    = fft8_pkg::BIN_WIDTH'(bank_im[idx]);
  assign bin_index = idx;
  assign last_bin  = (idx == fft8_pkg::LAST_IDX);

`ifndef NO_ASSERTIONS
  // An idle bank always restarts at bin zero.
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !bank_busy |-> (idx == '0))
    else $error("result bank idle with nonzero index");

  // A finished frame that finds the bank free is presented on the next cycle.
  a_bank_fill: assert property (@(posedge clk) disable iff (rst)
    bank_load |=> (bank_busy && idx == '0))
    else $error("result bank not filled after final stage");
`endif

endmodule

// File: hdl/fft_8_point_radix2_core.sv
// ----------------------------------------------------------------------------
// fft_8_point_radix2_core
// Streaming 8-point radix-2 decimation-in-time FFT with queue-style ports.
//
//   channel   direction  handshake     payload
//   samples   in         push / full   sample_re, sample_im
//   bins      out        pop / empty   bin_re, bin_im, bin_index, last_bin
//
// A sample beat is taken every cycle; full rises only on the eighth sample of
// a frame while both frame queue slots are occupied. The butterfly engine
// steps each frame through ENG_IDLE, ENG_ST2, ENG_TWID and ENG_ST3, and the
// result bank drains one bin per pop, so the engine can work on the next frame
// while the bank drains. The first bin appears once the eighth sample has passed
// the frame queue, ENG_ST2, ENG_TWID and ENG_ST3 into the result bank. Reset is
// synchronous; the sample buffer is not cleared. A stall on pop holds the current
// bin; upstream keeps flowing until the frame queue fills.
// ----------------------------------------------------------------------------
module fft_8_point_radix2_core #(
  parameter int SAMPLE_WIDTH      = fft8_pkg::SAMPLE_WIDTH_DEF,
  parameter int TWIDDLE_FRAC_BITS = fft8_pkg::TWIDDLE_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_im,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [fft8_pkg::BIN_WIDTH-1:0] bin_re,
  output logic signed [fft8_pkg::BIN_WIDTH-1:0] bin_im,
  output logic [fft8_pkg::IDX_WIDTH-1:0]        bin_index,
  output logic                                  last_bin
);

  localparam int FW = fft8_pkg::NPOINT * 2 * SAMPLE_WIDTH;

  logic          fifo_full;
  logic          fifo_empty;
  logic          frame_push;
  logic          frame_pop;
  logic [FW-1:0] frame_in;
  logic [FW-1:0] frame_out;

  // Sample collection.
  fft8_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample_re  (sample_re),
    .sample_im  (sample_im),
    .fifo_full  (fifo_full),
    .frame_push (frame_push),
    .frame      (frame_in)
  );

  // Frame queue between collection and computation.
  fft8_frame_fifo #(
    .WIDTH (FW),
    .DEPTH (fft8_pkg::FRAME_FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (frame_push),
    .wr_data (frame_in),
    .full    (fifo_full),
    .rd_en   (frame_pop),
    .rd_data (frame_out),
    .empty   (fifo_empty)
  );

  // Butterfly engine and result bank.
  fft8_engine #(
    .SAMPLE_WIDTH      (SAMPLE_WIDTH),
    .TWIDDLE_FRAC_BITS (TWIDDLE_FRAC_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (!fifo_empty),
    .frame       (frame_out),
    .frame_pop   (frame_pop),
    .empty       (empty),
    .pop         (pop),
    .bin_re      (bin_re),
    .bin_im      (bin_im),
    .bin_index   (bin_index),
    .last_bin    (last_bin)
  );

endmodule

// File: tb/sv/fft_8_point_radix2_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_8_point_radix2_core_test
// Self-checking bench for the streaming 8-point FFT core. Sample beats are
// fed by a stalling driver. Every complete frame is transformed by a
// behavioral FFT kept in the bench, and the eight bins it expects are compared
// field by field with the bins that the core returns.
// ----------------------------------------------------------------------------
module fft_8_point_radix2_core_test;

  localparam int SW              = fft8_pkg::SAMPLE_WIDTH_DEF;
  localparam int FRAC            = fft8_pkg::TWIDDLE_FRAC_BITS_DEF;
  localparam int NPOINT          = fft8_pkg::NPOINT;
  localparam int BIN_WIDTH       = fft8_pkg::BIN_WIDTH;
  localparam int IDX_WIDTH       = fft8_pkg::IDX_WIDTH;
  localparam int RANDOM_FRAMES   = 20;
  localparam int TAIL_SAMPLES    = 3;
  localparam int CALM_BEATS      = 40;
  localparam int HOLD_CYCLES     = 100;
  localparam int HOLD_AFTER_BINS = 48;
  localparam int DRAIN_CYCLES    = 40;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
  } sample_t;

  typedef struct packed {
    logic signed [BIN_WIDTH-1:0] re;
    logic signed [BIN_WIDTH-1:0] im;
    logic [IDX_WIDTH-1:0]        index;
    logic                        last;
  } bin_t;

  // Kinds of random frame content.
  typedef enum int {
    MIX_FULL,
    MIX_EXTREME,
    MIX_SMALL
  } mix_t;

  logic                        clk;
  logic                        rst;
  logic                        push;
  logic                        full;
  logic signed [SW-1:0]        sample_re;
  logic signed [SW-1:0]        sample_im;
  logic                        empty;
  logic                        pop;
  logic signed [BIN_WIDTH-1:0] bin_re;
  logic signed [BIN_WIDTH-1:0] bin_im;
  logic [IDX_WIDTH-1:0]        bin_index;
  logic                        last_bin;

  sample_t sample_queue[$];
  bin_t    expected_bins[$];
  longint  frame_re[NPOINT];
  longint  frame_im[NPOINT];
  longint  twid_c;
  int      frame_fill    = 0;
  int      samples_taken = 0;
  int      total_samples = 0;
  int      bins_seen     = 0;
  int      errors        = 0;
  int      send_gap      = 0;
  int      recv_gap      = 0;
  int      hold_left     = 0;
  bit      hold_done     = 1'b0;
  bit      calm          = 1'b0;
  bit      taken         = 1'b0;

  fft_8_point_radix2_core u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .empty     (empty),
    .pop       (pop),
    .bin_re    (bin_re),
    .bin_im    (bin_im),
    .bin_index (bin_index),
    .last_bin  (last_bin)
  );

  always #1 clk = ~clk;

  // Product with the 1/sqrt(2) twiddle, rounded to nearest with ties upward.
  function automatic longint twiddle_mul(longint x);
    return (x * twid_c + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // Transform the buffered frame and queue the eight bins it should yield.
  task automatic transform_frame();
    longint s1r[NPOINT], s1i[NPOINT], s2r[NPOINT], s2i[NPOINT];
    longint out_re[NPOINT], out_im[NPOINT];
    longint w1r, w1i, w3r, w3i;
    bin_t   b;
    // First stage: butterflies on samples n and n+4, bit-reversed pairing.
    s1r[0] = frame_re[0] + frame_re[4]; s1i[0] = frame_im[0] + frame_im[4];
    s1r[1] = frame_re[0] - frame_re[4]; s1i[1] = frame_im[0] - frame_im[4];
    s1r[2] = frame_re[2] + frame_re[6]; s1i[2] = frame_im[2] + frame_im[6];
    s1r[3] = frame_re[2] - frame_re[6]; s1i[3] = frame_im[2] - frame_im[6];
    s1r[4] = frame_re[1] + frame_re[5]; s1i[4] = frame_im[1] + frame_im[5];
    s1r[5] = frame_re[1] - frame_re[5]; s1i[5] = frame_im[1] - frame_im[5];
    s1r[6] = frame_re[3] + frame_re[7]; s1i[6] = frame_im[3] + frame_im[7];
    s1r[7] = frame_re[3] - frame_re[7]; s1i[7] = frame_im[3] - frame_im[7];
    // Second stage: 4-point butterflies, the odd term rotated by -j.
    s2r[0] = s1r[0] + s1r[2]; s2i[0] = s1i[0] + s1i[2];
    s2r[2] = s1r[0] - s1r[2]; s2i[2] = s1i[0] - s1i[2];
    s2r[1] = s1r[1] + s1i[3]; s2i[1] = s1i[1] - s1r[3];
    s2r[3] = s1r[1] - s1i[3]; s2i[3] = s1i[1] + s1r[3];
    s2r[4] = s1r[4] + s1r[6]; s2i[4] = s1i[4] + s1i[6];
    s2r[6] = s1r[4] - s1r[6]; s2i[6] = s1i[4] - s1i[6];
    s2r[5] = s1r[5] + s1i[7]; s2i[5] = s1i[5] - s1r[7];
    s2r[7] = s1r[5] - s1i[7]; s2i[7] = s1i[5] + s1r[7];
    // Odd twiddles: W8^1 = C(1-j) and W8^3 = -C(1+j).
    w1r = twiddle_mul(s2r[5] + s2i[5]);
    w1i = twiddle_mul(s2i[5] - s2r[5]);
    w3r = twiddle_mul(s2i[7] - s2r[7]);
    w3i = twiddle_mul(-(s2r[7] + s2i[7]));
    // Third stage gives the bins in natural order.
    out_re[0] = s2r[0] + s2r[4]; out_im[0] = s2i[0] + s2i[4];
    out_re[4] = s2r[0] - s2r[4]; out_im[4] = s2i[0] - s2i[4];
    out_re[1] = s2r[1] + w1r;    out_im[1] = s2i[1] + w1i;
    out_re[5] = s2r[1] - w1r;    out_im[5] = s2i[1] - w1i;
    out_re[2] = s2r[2] + s2i[6]; out_im[2] = s2i[2] - s2r[6];
    out_re[6] = s2r[2] - s2i[6]; out_im[6] = s2i[2] + s2r[6];
    out_re[3] = s2r[3] + w3r;    out_im[3] = s2i[3] + w3i;
    out_re[7] = s2r[3] - w3r;    out_im[7] = s2i[3] - w3i;
    for (int k = 0; k < NPOINT; k++) begin
      b.re    = BIN_WIDTH'(out_re[k]);
      b.im    = BIN_WIDTH'(out_im[k]);
      b.index = IDX_WIDTH'(k);
      b.last  = (k == NPOINT - 1);
      expected_bins.push_back(b);
    end
  endtask

  // One random sample component of the given kind.
  function automatic logic signed [SW-1:0] pick_value(mix_t mix);
    case (mix)
      MIX_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          3:       return '1;
          4:       return SW'(1);
          default: return SW'($urandom);
        endcase
      end
      MIX_SMALL: return SW'(int'($urandom_range(0, 127)) - 64);
      default:   return SW'($urandom);
    endcase
  endfunction

  task automatic queue_sample(logic signed [SW-1:0] re, logic signed [SW-1:0] im);
    sample_t s;
    s.re = re;
    s.im = im;
    sample_queue.push_back(s);
  endtask

  // Sample driver: holds a beat until it is taken, with random idle bursts.
  always @(negedge clk) begin : drive_samples
    sample_t beat;
    if (!rst && (!push || taken)) begin
      if (send_gap > 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        push <= 1'b0;
        send_gap = $urandom_range(0, 5);
      end else if (sample_queue.size() > 0) begin
        beat = sample_queue.pop_front();
        push      <= 1'b1;
        sample_re <= beat.re;
        sample_im <= beat.im;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Bin receiver: random stalls, plus one long hold-off that backs up the core.
  always @(negedge clk) begin : drive_pop
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (!hold_done && bins_seen >= HOLD_AFTER_BINS) begin
      pop <= 1'b0;
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
    end else if (recv_gap > 0) begin
      pop <= 1'b0;
      recv_gap--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      recv_gap = $urandom_range(0, 5);
    end else begin
      pop <= 1'b1;
    end
  end

  // Capture accepted samples into the frame and check every bin beat.
  always @(posedge clk) begin : check_bins
    bin_t want;
    bin_t got;
    taken = !rst && push && !full;
    if (taken) begin
      frame_re[frame_fill] = longint'(sample_re);
      frame_im[frame_fill] = longint'(sample_im);
      samples_taken++;
      if (samples_taken >= total_samples - CALM_BEATS) begin
        calm = 1'b1;
      end
      if (frame_fill == NPOINT - 1) begin
        frame_fill = 0;
        transform_frame();
      end else begin
        frame_fill++;
      end
    end
    if (!rst && pop && !empty) begin
      got = {bin_re, bin_im, bin_index, last_bin};
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected bin beat re=%0d im=%0d index=%0d last=%0b", $time,
                 bin_re, bin_im, bin_index, last_bin);
        errors++;
      end else begin
        want = expected_bins.pop_front();
        if (got !== want) begin
          $display("%0t: bin mismatch expected re=%0d im=%0d index=%0d last=%0b", $time,
                   want.re, want.im, want.index, want.last);
          $display("%0t:              actual   re=%0d im=%0d index=%0d last=%0b", $time,
                   got.re, got.im, got.index, got.last);
          errors++;
        end
      end
      bins_seen++;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run
    mix_t mix;
    clk       = 1'b0;
    rst       = 1'b1;
    push      = 1'b0;
    pop       = 1'b0;
    sample_re = '0;
    sample_im = '0;
    twid_c    = longint'($rtoi(0.70710678118654752440 * (2.0 ** FRAC) + 0.5));

    // Directed frames: full-scale DC, most negative DC, and alternating extremes
    // that drive the twiddle path hardest.
    for (int k = 0; k < NPOINT; k++) queue_sample(S_MAX, S_MIN);
    for (int k = 0; k < NPOINT; k++) queue_sample(S_MIN, S_MIN);
    for (int k = 0; k < NPOINT; k++) begin
      queue_sample((k % 2) ? S_MIN : S_MAX, (k % 4 < 2) ? S_MAX : S_MIN);
    end

    // Random frames of mixed character, then a partial frame that must stay silent.
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      mix = mix_t'($urandom_range(0, 2));
      for (int k = 0; k < NPOINT; k++) queue_sample(pick_value(mix), pick_value(mix));
    end
    for (int k = 0; k < TAIL_SAMPLES; k++) begin
      queue_sample(pick_value(MIX_FULL), pick_value(MIX_FULL));
    end
    total_samples = sample_queue.size();

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (samples_taken == total_samples);
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS fft_8_point_radix2_core");
    end else begin
      $display("FAIL fft_8_point_radix2_core");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #100000;
    $display("FAIL fft_8_point_radix2_core");
    $finish;
  end

endmodule
